// ----- rtl/book_sequence_recovery_tracker_core_assert.svh -----
// assertion macros for the sequence recovery tracker
// used by the top level only, no other dependencies
`ifndef BOOK_SEQUENCE_RECOVERY_TRACKER_CORE_ASSERT_SVH
`define BOOK_SEQUENCE_RECOVERY_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTH
`define BSRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequence tracker check failed");
`define BSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequence tracker check failed");
`else
`define BSRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bsrt_pkg.sv -----
// shared types and codes for the sequence recovery tracker
// no dependencies
package bsrt_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 32;
    localparam int ID_W = 64;

    localparam logic [1:0] MODE_UPDATE     = 2'd0;
    localparam logic [1:0] MODE_SNAPSHOT   = 2'd1;
    localparam logic [1:0] MODE_DISCONNECT = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_BUFFERING = 2'd1,
        PH_SYNCED    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_APPLY    = 3'd0,
        ACT_STALE    = 3'd1,
        ACT_BUFFERED = 3'd2,
        ACT_BUF_REQ  = 3'd3,
        ACT_RESYNC   = 3'd4,
        ACT_SYNCED   = 3'd5,
        ACT_IGNORED  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP2,
        S_DRAIN_RD,
        S_CHK1,
        S_CHK2,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] last_id;
        logic [ID_W-1:0] prev_last_id;
        logic [ID_W-1:0] snapshot_id;
    } in_item_t;

    typedef struct packed {
        action_t         action;
        logic [ID_W-1:0] applied_first_id;
        logic [ID_W-1:0] applied_last_id;
        logic            end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] last_id;
        logic [ID_W-1:0] prev_id;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ----- rtl/book_sequence_recovery_tracker_core.sv -----
// top level of the sequence recovery tracker: sequencer, state and output register
// depends on bsrt_pkg, bsrt_queue, bsrt_cmp and the assertion macro header
//
//   channel | ports            | payload    | direction
//   --------+------------------+------------+----------
//   input   | s_valid, s_ready | s_data     | in
//   result  | m_valid, m_ready | m_data     | out
//
// update while idle or buffering, disconnect, ignored, stale update while synced: straight to emit;
// other updates while synced: through S_CMP2, a second pass through the one 64-bit comparator
// snapshot drain: S_DRAIN_RD, S_CHK1 and, for a kept entry, S_CHK2 per entry, one queue read each
// reset clears phase, ids and fill; the queue itself is never cleared
// a new item is taken while the last result waits in the output register; a stalled
// m_ready holds the sequencer in its emit step
`include "book_sequence_recovery_tracker_core_assert.svh"

module book_sequence_recovery_tracker_core import bsrt_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);

    seq_state_t      state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [ID_W-1:0] held_snap_reg, held_snap_next;
    logic [ID_W-1:0] la_reg, la_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic            found_reg, found_next;
    in_item_t        item_reg, item_next;
    out_item_t       res_reg, res_next;
    out_item_t       out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    entry_t          entry;

    logic [ID_W-1:0] cmp_a, cmp_b;
    cmp_res_t        cmp;
    logic            la_nz;
    logic            out_free;
    logic            chk_ok;

    bsrt_queue #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    bsrt_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    assign la_nz    = |la_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // comparator operand selection, one check per cycle
    always_comb begin
        cmp_a = s_data.last_id;
        cmp_b = la_reg;
        case (state_reg)
            S_CMP2: begin
                cmp_a = item_reg.prev_last_id;
                cmp_b = la_reg;
            end
            S_CHK1: begin
                cmp_a = entry.last_id;
                cmp_b = held_snap_reg;
            end
            S_CHK2: begin
                cmp_a = found_reg ? entry.prev_id : entry.first_id;
                cmp_b = found_reg ? la_reg : held_snap_reg;
            end
            default: begin
                cmp_a = s_data.last_id;
                cmp_b = la_reg;
            end
        endcase
    end

    // bridge check for the first kept entry, chain check after it
    assign chk_ok = found_reg ? cmp.eq : (cmp.lt || cmp.eq);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EMIT;
                    if (s_data.mode == MODE_UPDATE && phase_reg == PH_SYNCED) begin
                        if (!(la_nz && (cmp.lt || cmp.eq))) begin
                            state_next = S_CMP2;
                        end
                    end else if (s_data.mode == MODE_SNAPSHOT
                                 && phase_reg == PH_BUFFERING) begin
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            S_CMP2: begin
                state_next = S_EMIT;
            end
            S_DRAIN_RD: begin
                state_next = (idx_reg == fill_reg) ? S_EMIT : S_CHK1;
            end
            S_CHK1: begin
                state_next = cmp.lt ? S_EMIT : S_CHK2;
            end
            S_CHK2: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = res_reg.end_of_run ? S_IDLE : S_DRAIN_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        phase_next     = phase_reg;
        held_snap_next = held_snap_reg;
        la_next        = la_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[AW-1:0];
        wr_data        = '{first_id: s_data.first_id, last_id: s_data.last_id,
                           prev_id: s_data.prev_last_id};
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    res_next  = '{action: ACT_IGNORED, applied_first_id: '0,
                                  applied_last_id: '0, end_of_run: 1'b1};
                    case (s_data.mode)
                        MODE_UPDATE: begin
                            res_next.applied_first_id = s_data.first_id;
                            res_next.applied_last_id  = s_data.last_id;
                            case (phase_reg)
                                PH_BUFFERING: begin
                                    if (fill_reg == FILL_FULL) begin
                                        phase_next      = PH_IDLE;
                                        held_snap_next  = '0;
                                        la_next         = '0;
                                        fill_next       = '0;
                                        res_next.action = ACT_RESYNC;
                                    end else begin
                                        wr_en           = 1'b1;
                                        fill_next       = fill_reg + FW'(1);
                                        res_next.action = ACT_BUFFERED;
                                    end
                                end
                                PH_SYNCED: begin
                                    // stale here, chain check follows otherwise
                                    res_next.action = ACT_STALE;
                                end
                                default: begin
                                    wr_en           = 1'b1;
                                    wr_addr         = '0;
                                    phase_next      = PH_BUFFERING;
                                    held_snap_next  = '0;
                                    la_next         = '0;
                                    fill_next       = FW'(1);
                                    res_next.action = ACT_BUF_REQ;
                                end
                            endcase
                        end
                        MODE_SNAPSHOT: begin
                            if (phase_reg == PH_BUFFERING) begin
                                held_snap_next = s_data.snapshot_id;
                                idx_next       = '0;
                                found_next     = 1'b0;
                            end
                        end
                        MODE_DISCONNECT: begin
                            phase_next      = PH_IDLE;
                            held_snap_next  = '0;
                            la_next         = '0;
                            fill_next       = '0;
                            res_next.action = ACT_RESYNC;
                        end
                        default: begin
                            res_next.action = ACT_IGNORED;
                        end
                    endcase
                end
            end
            S_CMP2: begin
                res_next = '{action: ACT_APPLY, applied_first_id: item_reg.first_id,
                             applied_last_id: item_reg.last_id, end_of_run: 1'b1};
                if (la_nz && !cmp.eq) begin
                    phase_next      = PH_IDLE;
                    held_snap_next  = '0;
                    la_next         = '0;
                    fill_next       = '0;
                    res_next.action = ACT_RESYNC;
                end else begin
                    la_next = item_reg.last_id;
                end
            end
            S_DRAIN_RD: begin
                if (idx_reg == fill_reg) begin
                    fill_next  = '0;
                    phase_next = PH_SYNCED;
                    res_next   = '{action: ACT_SYNCED, applied_first_id: held_snap_reg,
                                   applied_last_id: held_snap_reg, end_of_run: 1'b1};
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_CHK1: begin
                res_next = '{action: ACT_STALE, applied_first_id: entry.first_id,
                             applied_last_id: entry.last_id, end_of_run: 1'b0};
                if (cmp.lt) begin
                    idx_next = idx_reg + FW'(1);
                end
            end
            S_CHK2: begin
                res_next = '{action: ACT_APPLY, applied_first_id: entry.first_id,
                             applied_last_id: entry.last_id, end_of_run: 1'b0};
                if (!chk_ok) begin
                    phase_next          = PH_IDLE;
                    held_snap_next      = '0;
                    la_next             = '0;
                    fill_next           = '0;
                    res_next.action     = ACT_RESYNC;
                    res_next.end_of_run = 1'b1;
                end else begin
                    found_next = 1'b1;
                    la_next    = entry.last_id;
                    idx_next   = idx_reg + FW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            held_snap_reg <= '0;
            la_reg        <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_snap_reg <= held_snap_next;
            la_reg        <= la_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    `BSRT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BSRT_ASSERT_IMPL(a_fill_in_range, aclk, aresetn, 1'b1, fill_reg <= FILL_FULL)
    `BSRT_ASSERT_IMPL(a_fill_empty_unbuffered, aclk, aresetn, phase_reg != PH_BUFFERING, fill_reg == '0)
    `BSRT_ASSERT_IMPL(a_drain_index, aclk, aresetn, (state_reg == S_CHK1) || (state_reg == S_CHK2), idx_reg < fill_reg)

endmodule

// ----- rtl/bsrt_queue.sv -----
// update queue: one write port, one registered read port
// depends on bsrt_pkg for the entry type
module bsrt_queue import bsrt_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bsrt_cmp.sv -----
// shared 64-bit magnitude and equality comparator
// depends on bsrt_pkg for the result struct
module bsrt_cmp import bsrt_pkg::*; (
    input  logic [ID_W-1:0] a,
    input  logic [ID_W-1:0] b,
    output cmp_res_t        res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule
